[hw/rtl/shfs_pkg.sv]
// Shared types, constants and helper functions for the stereo smoothing filter stack.
package shfs_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int WORD_W      = 32;
    localparam int FRAC_BITS   = 8;
    localparam int GAIN_BITS   = 14;
    localparam int SHIFT_W     = 5;
    localparam int STAGES_W    = 4;
    localparam int WET_W       = 16;
    localparam int DRY_W       = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = 48;
    localparam int ACC_W       = PROD_W + 1;
    localparam int MIX_W       = ACC_W - GAIN_BITS - FRAC_BITS;

    localparam logic [SHIFT_W-1:0]  SHIFT_LIMIT     = 5'd16;
    localparam logic [SHIFT_W-1:0]  FREQ_SHIFT_RST  = 5'd10;
    localparam logic [STAGES_W-1:0] ACT_STAGES_RST  = 4'd8;
    localparam logic [WET_W-1:0]    WET_GAIN_RST    = 16'd16384;
    localparam logic [DRY_W-1:0]    DRY_GAIN_RST    = 15'd0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WORD_W-1:0]   word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_SHIFT    = 2'd0,
        REG_ACTIVE_STAGES = 2'd1,
        REG_WET_GAIN      = 2'd2,
        REG_DRY_GAIN      = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LVL,
        ST_RD_SLW,
        ST_SUM,
        ST_WR_SLW,
        ST_WR_LVL,
        ST_MUL_WET,
        ST_MUL_DRY,
        ST_MIX
    } seq_state_t;

    function automatic word_t sat_word(input logic signed [WORD_W+2:0] v);
        logic signed [WORD_W+2:0] hi;
        logic signed [WORD_W+2:0] lo;
        hi = (WORD_W+3)'(signed'({1'b0, {(WORD_W-1){1'b1}}}));
        lo = (WORD_W+3)'(signed'({1'b1, {(WORD_W-1){1'b0}}}));
        if (v > hi)
            return hi[WORD_W-1:0];
        else if (v < lo)
            return lo[WORD_W-1:0];
        return v[WORD_W-1:0];
    endfunction

    function automatic sample_t sat_sample(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] hi;
        logic signed [MIX_W-1:0] lo;
        hi = MIX_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
        lo = MIX_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}));
        if (v > hi)
            return hi[SAMPLE_W-1:0];
        else if (v < lo)
            return lo[SAMPLE_W-1:0];
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

[hw/rtl/shfs_if.sv]
// Valid/ready channel interfaces for input frames and mixed output frames.
interface shfs_in_if
    import shfs_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;
    logic    block_end;

    modport source (output valid, output left_sample, output right_sample,
                    output block_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input block_end, output ready);
endinterface

interface shfs_out_if
    import shfs_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;
    logic    block_end_out;

    modport source (output valid, output left_out, output right_out,
                    output block_end_out, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input block_end_out, output ready);
endinterface

[hw/rtl/shfs_stage_mem.sv]
// Stage state memory: one write port, one registered read port, per-word valid bits.
module shfs_stage_mem
    import shfs_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  word_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output word_t         rd_data
);

    word_t            mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    word_t            rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem_reg[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/stereo_holt_filter_stack.sv]
// Stereo cascade of shift-coefficient Holt smoothing stages with wet/dry mix.
// One frame at a time: input ready stays low until the mixed result is registered, and a
// stalled output holds the mix state. Each stage of each channel reads level and slope,
// sums, then writes slope and level on the single stage memory; the mix uses one multiplier.
// Reset: asynchronous, active low; configuration registers take their defaults, stage
// state reads zero through per-word valid bits, so no clearing pass is needed.
module stereo_holt_filter_stack
    import shfs_pkg::*;
#(
    parameter int MAX_STAGES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    shfs_in_if.sink               in_ch,
    shfs_out_if.source            out_ch
);

    localparam int SW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int NW    = $clog2(MAX_STAGES + 1);
    localparam int CW    = (NW > STAGES_W) ? NW : STAGES_W;
    localparam int AW    = SW + 2;
    localparam int DEPTH = 4 * MAX_STAGES;

    logic [SHIFT_W-1:0]       freq_shift_reg;
    logic [STAGES_W-1:0]      active_stages_reg;
    logic signed [WET_W-1:0]  wet_gain_reg;
    logic [DRY_W-1:0]         dry_gain_reg;

    seq_state_t state_reg, state_next;

    logic [SHIFT_W-1:0]       sh_reg;
    logic [NW-1:0]            n_reg;
    logic [SW-1:0]            stage_reg;
    logic                     ch_reg;
    word_t                    raw_l_reg, raw_r_reg;
    word_t                    y_reg, lvl_reg;
    word_t                    filt_l_reg, filt_r_reg;
    logic signed [WORD_W:0]   sum_reg;
    logic signed [WORD_W+1:0] diff_reg;
    logic signed [WORD_W+1:0] part_reg;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    sample_t                  hold_l_reg;
    logic                     be_reg;
    logic                     out_valid_reg;
    sample_t                  out_l_reg, out_r_reg;
    logic                     out_be_reg;

    logic                     accept;
    logic [SHIFT_W-1:0]       sh_clamp;
    logic [CW-1:0]            act_ext;
    logic [NW-1:0]            n_clamp;
    logic                     last_stage;
    logic                     out_free;
    word_t                    rd_data;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    word_t                    wr_data;
    logic signed [WET_W-1:0]  mul_a;
    word_t                    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [WORD_W:0]   sum_calc;
    logic signed [WORD_W+1:0] diff_calc;
    logic signed [WORD_W+1:0] part_calc;
    word_t                    slw_new;
    word_t                    lvl_new;
    logic signed [ACC_W-1:0]  acc;
    sample_t                  mix_out;
    word_t                    in_raw_l, in_raw_r;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign sh_clamp = (freq_shift_reg > SHIFT_LIMIT) ? SHIFT_LIMIT : freq_shift_reg;
    assign act_ext  = CW'(active_stages_reg);
    assign n_clamp  = (act_ext > CW'(MAX_STAGES)) ? NW'(MAX_STAGES) : NW'(act_ext);
    assign last_stage = (NW'(stage_reg) == n_reg - NW'(1));

    assign in_raw_l = word_t'(in_ch.left_sample) <<< FRAC_BITS;
    assign in_raw_r = word_t'(in_ch.right_sample) <<< FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_shift_reg    <= FREQ_SHIFT_RST;
            active_stages_reg <= ACT_STAGES_RST;
            wet_gain_reg      <= WET_GAIN_RST;
            dry_gain_reg      <= DRY_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FREQ_SHIFT:    freq_shift_reg    <= cfg_data[SHIFT_W-1:0];
                REG_ACTIVE_STAGES: active_stages_reg <= cfg_data[STAGES_W-1:0];
                REG_WET_GAIN:      wet_gain_reg      <= cfg_data[WET_W-1:0];
                REG_DRY_GAIN:      dry_gain_reg      <= cfg_data[DRY_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (n_clamp == '0) ? ST_MUL_WET : ST_RD_LVL;
            end
            ST_RD_LVL:  state_next = ST_RD_SLW;
            ST_RD_SLW:  state_next = ST_SUM;
            ST_SUM:     state_next = ST_WR_SLW;
            ST_WR_SLW:  state_next = ST_WR_LVL;
            ST_WR_LVL:  state_next = (last_stage && ch_reg) ? ST_MUL_WET : ST_RD_LVL;
            ST_MUL_WET: state_next = ST_MUL_DRY;
            ST_MUL_DRY: state_next = ST_MIX;
            ST_MIX:
            begin
                if (!ch_reg)
                    state_next = ST_MUL_WET;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rd_addr = {stage_reg, ch_reg, 1'b0};
        wr_en   = 1'b0;
        wr_addr = {stage_reg, ch_reg, 1'b0};
        wr_data = lvl_new;
        mul_a   = wet_gain_reg;
        mul_b   = ch_reg ? filt_r_reg : filt_l_reg;
        case (state_reg)
            ST_RD_SLW:
            begin
                rd_addr = {stage_reg, ch_reg, 1'b1};
            end
            ST_WR_SLW:
            begin
                wr_en   = 1'b1;
                wr_addr = {stage_reg, ch_reg, 1'b1};
                wr_data = slw_new;
            end
            ST_WR_LVL:
            begin
                wr_en = 1'b1;
            end
            ST_MUL_DRY:
            begin
                mul_a = signed'({1'b0, dry_gain_reg});
                mul_b = ch_reg ? raw_r_reg : raw_l_reg;
            end
            default: ;
        endcase
    end

    assign sum_calc  = (WORD_W+1)'(lvl_reg) + (WORD_W+1)'(rd_data);
    assign diff_calc = (WORD_W+2)'(y_reg) - (WORD_W+2)'(lvl_reg) + (WORD_W+2)'(rd_data);
    assign part_calc = (WORD_W+2)'(sum_reg) - (WORD_W+2)'(sum_reg >>> sh_reg);
    assign slw_new   = sat_word((WORD_W+3)'(diff_reg >>> ({1'b0, sh_reg} + 6'd1)));
    assign lvl_new   = sat_word((WORD_W+3)'(y_reg >>> sh_reg) + (WORD_W+3)'(part_reg));
    assign mul_p     = mul_a * mul_b;
    assign acc       = ACC_W'(prod_a_reg) + ACC_W'(prod_b_reg);
    assign mix_out   = sat_sample(MIX_W'(acc >>> (GAIN_BITS + FRAC_BITS)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ch_reg        <= 1'b0;
            stage_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MIX && ch_reg && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    ch_reg    <= 1'b0;
                    stage_reg <= '0;
                end
                ST_WR_LVL:
                begin
                    if (last_stage)
                    begin
                        stage_reg <= '0;
                        ch_reg    <= !ch_reg;
                    end
                    else
                    begin
                        stage_reg <= stage_reg + SW'(1);
                    end
                end
                ST_MIX:
                begin
                    if (!ch_reg)
                        ch_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    raw_l_reg  <= in_raw_l;
                    raw_r_reg  <= in_raw_r;
                    y_reg      <= in_raw_l;
                    filt_l_reg <= in_raw_l;
                    filt_r_reg <= in_raw_r;
                    be_reg     <= in_ch.block_end;
                    sh_reg     <= sh_clamp;
                    n_reg      <= n_clamp;
                end
            end
            ST_RD_SLW:  lvl_reg <= rd_data;
            ST_SUM:
            begin
                sum_reg  <= sum_calc;
                diff_reg <= diff_calc;
            end
            ST_WR_SLW:  part_reg <= part_calc;
            ST_WR_LVL:
            begin
                if (last_stage && !ch_reg)
                begin
                    filt_l_reg <= lvl_new;
                    y_reg      <= raw_r_reg;
                end
                else
                begin
                    y_reg <= lvl_new;
                    if (last_stage)
                        filt_r_reg <= lvl_new;
                end
            end
            ST_MUL_WET: prod_a_reg <= mul_p;
            ST_MUL_DRY: prod_b_reg <= mul_p;
            ST_MIX:
            begin
                if (!ch_reg)
                begin
                    hold_l_reg <= mix_out;
                end
                else if (out_free)
                begin
                    out_l_reg  <= hold_l_reg;
                    out_r_reg  <= mix_out;
                    out_be_reg <= be_reg;
                end
            end
            default: ;
        endcase
    end

    shfs_stage_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ch.ready          = (state_reg == ST_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.left_out      = out_l_reg;
    assign out_ch.right_out     = out_r_reg;
    assign out_ch.block_end_out = out_be_reg;

endmodule

[hw/rtl/shfs_checker.sv]
// Port-level assertions for the filter stack, bound to the top level.
module shfs_checker
    import shfs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t out_left,
    input sample_t out_right,
    input logic    out_be
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped without a transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_left) && $stable(out_right) && $stable(out_be))
        else $error("stalled output payload changed");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready high right after an input transfer");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while no frame was in progress");

endmodule

bind stereo_holt_filter_stack shfs_checker u_shfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_left  (out_ch.left_out),
    .out_right (out_ch.right_out),
    .out_be    (out_ch.block_end_out)
);
